// ----- rtl/crps_pkg.sv -----
// ----------------------------------------------------------------------------
// crps_pkg
// Shared constants and types of the co-rated pearson similarity block.
// ----------------------------------------------------------------------------
package crps_pkg;

  localparam int NumItemsDef   = 8;
  localparam int RatingBitsDef = 4;
  localparam int InWidth       = 32;
  localparam int FracBits      = 28;
  localparam int QuotBits      = FracBits + 1;
  localparam int RootBits      = FracBits / 2 + 1;
  localparam int SimWidth      = 16;
  localparam int CountWidth    = 4;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_NO_COMMON = 2'd1,
    ST_ZERO_VAR  = 2'd2
  } status_t;

endpackage

// ----- rtl/crps_acc_cell.sv -----
// ----------------------------------------------------------------------------
// crps_acc_cell
// One item of the sum chain: adds its co-rated pair into the running sums.
// ----------------------------------------------------------------------------
module crps_acc_cell #(
  parameter int IDX         = 0,
  parameter int RATING_BITS = crps_pkg::RatingBitsDef,
  parameter int EXT_W       = crps_pkg::InWidth,
  parameter int CNT_W       = 4,
  parameter int SUM_W       = 8,
  parameter int SQ_W        = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [EXT_W-1:0] in_a,
  input  logic [EXT_W-1:0] in_b,
  input  logic [CNT_W-1:0] in_n,
  input  logic [SUM_W-1:0] in_sa,
  input  logic [SUM_W-1:0] in_sb,
  input  logic [SQ_W-1:0]  in_sab,
  input  logic [SQ_W-1:0]  in_saa,
  input  logic [SQ_W-1:0]  in_sbb,
  output logic             out_valid,
  output logic [EXT_W-1:0] out_a,
  output logic [EXT_W-1:0] out_b,
  output logic [CNT_W-1:0] out_n,
  output logic [SUM_W-1:0] out_sa,
  output logic [SUM_W-1:0] out_sb,
  output logic [SQ_W-1:0]  out_sab,
  output logic [SQ_W-1:0]  out_saa,
  output logic [SQ_W-1:0]  out_sbb
);

  logic [RATING_BITS-1:0] ra, rb;
  logic                   both;
  logic [SQ_W-1:0]        ra_x, rb_x;

  assign ra   = in_a[IDX*RATING_BITS +: RATING_BITS];
  assign rb   = in_b[IDX*RATING_BITS +: RATING_BITS];
  assign both = (|ra) && (|rb);
  assign ra_x = both ? SQ_W'(ra) : '0;
  assign rb_x = both ? SQ_W'(rb) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_a   <= in_a;
    out_b   <= in_b;
    out_n   <= in_n + CNT_W'(both);
    out_sa  <= in_sa + SUM_W'(ra_x);
    out_sb  <= in_sb + SUM_W'(rb_x);
    out_sab <= in_sab + ra_x * rb_x;
    out_saa <= in_saa + ra_x * ra_x;
    out_sbb <= in_sbb + rb_x * rb_x;
  end

endmodule

// ----- rtl/crps_div_cell.sv -----
// ----------------------------------------------------------------------------
// crps_div_cell
// One restoring step of the scaled ratio: shifts the remainder, one bit out.
// ----------------------------------------------------------------------------
module crps_div_cell #(
  parameter int PW    = 50,
  parameter int CNT_W = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [PW-1:0]                   in_rem,
  input  logic [PW-1:0]                   in_p,
  input  logic [crps_pkg::QuotBits-1:0]   in_quot,
  input  logic                            in_neg,
  input  logic [CNT_W-1:0]                in_n,
  input  crps_pkg::status_t               in_status,
  output logic                            out_valid,
  output logic [PW-1:0]                   out_rem,
  output logic [PW-1:0]                   out_p,
  output logic [crps_pkg::QuotBits-1:0]   out_quot,
  output logic                            out_neg,
  output logic [CNT_W-1:0]                out_n,
  output crps_pkg::status_t               out_status
);

  logic [PW:0] r2, diff;
  logic        ge;

  assign r2   = {in_rem, 1'b0};
  assign ge   = r2 >= {1'b0, in_p};
  assign diff = r2 - {1'b0, in_p};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem    <= ge ? diff[PW-1:0] : r2[PW-1:0];
    out_quot   <= {in_quot[crps_pkg::QuotBits-2:0], ge};
    out_p      <= in_p;
    out_neg    <= in_neg;
    out_n      <= in_n;
    out_status <= in_status;
  end

endmodule

// ----- rtl/crps_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// crps_sqrt_cell
// One digit of the integer square root: decides root bit BIT.
// ----------------------------------------------------------------------------
module crps_sqrt_cell #(
  parameter int BIT   = 0,
  parameter int CNT_W = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [crps_pkg::QuotBits-1:0]   in_rem,
  input  logic [crps_pkg::RootBits-1:0]   in_root,
  input  logic                            in_neg,
  input  logic [CNT_W-1:0]                in_n,
  input  crps_pkg::status_t               in_status,
  output logic                            out_valid,
  output logic [crps_pkg::QuotBits-1:0]   out_rem,
  output logic [crps_pkg::RootBits-1:0]   out_root,
  output logic                            out_neg,
  output logic [CNT_W-1:0]                out_n,
  output crps_pkg::status_t               out_status
);

  localparam int TW = 2 * crps_pkg::RootBits + 1;

  logic [TW-1:0] trial, rem_x;
  logic          ge;

  assign trial = (TW'(in_root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign rem_x = TW'(in_rem);
  assign ge    = rem_x >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem    <= ge ? crps_pkg::QuotBits'(rem_x - trial) : in_rem;
    out_root   <= ge ? (in_root | (crps_pkg::RootBits'(1) << BIT)) : in_root;
    out_neg    <= in_neg;
    out_n      <= in_n;
    out_status <= in_status;
  end

endmodule

// ----- rtl/co_rated_pearson_similarity.sv -----
// ----------------------------------------------------------------------------
// co_rated_pearson_similarity
// Pearson correlation of two packed rating vectors over co-rated items.
// ----------------------------------------------------------------------------
// usage:
//   raise start with in_ratings_a / in_ratings_b; a request is taken at every
//   clock edge where start is high (busy is always low, the chain is fully
//   pipelined), so one pair per cycle is taken.
//   each request yields one result: out_valid is high for one cycle with
//   out_similarity (signed q2.14), out_co_rated_count and out_status.
//   the pipeline is one cell per item for the sums, three stages for
//   variances, products and divider setup, 28 divider cells and 15 root
//   cells, then the output register. throughput is one result per cycle.
//   status no common items or zero variance gives similarity 0.
//   the receiver cannot stall; results appear in request order.
//   synchronous reset drops every request in flight and clears out_valid.
// ----------------------------------------------------------------------------
module co_rated_pearson_similarity #(
  parameter int NUM_ITEMS   = crps_pkg::NumItemsDef,
  parameter int RATING_BITS = crps_pkg::RatingBitsDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [crps_pkg::InWidth-1:0]        in_ratings_a,
  input  logic [crps_pkg::InWidth-1:0]        in_ratings_b,
  output logic                                out_valid,
  output logic signed [crps_pkg::SimWidth-1:0] out_similarity,
  output logic [crps_pkg::CountWidth-1:0]     out_co_rated_count,
  output logic [1:0]                          out_status
);

  localparam int PACK_W = NUM_ITEMS * RATING_BITS;
  localparam int EXT_W  = (PACK_W > crps_pkg::InWidth) ? PACK_W : crps_pkg::InWidth;
  localparam int CNT_W  = $clog2(NUM_ITEMS + 1);
  localparam int SUM_W  = RATING_BITS + CNT_W;
  localparam int SQ_W   = 2 * RATING_BITS + CNT_W;
  localparam int VW     = 2 * RATING_BITS + 2 * CNT_W + 1;
  localparam int MW     = VW - 1;
  localparam int PW     = 2 * MW;
  localparam int QB     = crps_pkg::QuotBits;
  localparam int RB     = crps_pkg::RootBits;
  localparam int NDIV   = crps_pkg::FracBits;

  assign busy = 1'b0;

  // sum chain
  logic             av [0:NUM_ITEMS];
  logic [EXT_W-1:0] aa [0:NUM_ITEMS];
  logic [EXT_W-1:0] ab [0:NUM_ITEMS];
  logic [CNT_W-1:0] an [0:NUM_ITEMS];
  logic [SUM_W-1:0] asa [0:NUM_ITEMS];
  logic [SUM_W-1:0] asb [0:NUM_ITEMS];
  logic [SQ_W-1:0]  asab [0:NUM_ITEMS];
  logic [SQ_W-1:0]  asaa [0:NUM_ITEMS];
  logic [SQ_W-1:0]  asbb [0:NUM_ITEMS];

  assign av[0]   = start;
  assign aa[0]   = EXT_W'(in_ratings_a);
  assign ab[0]   = EXT_W'(in_ratings_b);
  assign an[0]   = '0;
  assign asa[0]  = '0;
  assign asb[0]  = '0;
  assign asab[0] = '0;
  assign asaa[0] = '0;
  assign asbb[0] = '0;

  for (genvar i = 0; i < NUM_ITEMS; i++) begin : g_acc
    crps_acc_cell #(
      .IDX(i), .RATING_BITS(RATING_BITS), .EXT_W(EXT_W),
      .CNT_W(CNT_W), .SUM_W(SUM_W), .SQ_W(SQ_W)
    ) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(av[i]), .in_a(aa[i]), .in_b(ab[i]), .in_n(an[i]),
      .in_sa(asa[i]), .in_sb(asb[i]), .in_sab(asab[i]),
      .in_saa(asaa[i]), .in_sbb(asbb[i]),
      .out_valid(av[i+1]), .out_a(aa[i+1]), .out_b(ab[i+1]), .out_n(an[i+1]),
      .out_sa(asa[i+1]), .out_sb(asb[i+1]), .out_sab(asab[i+1]),
      .out_saa(asaa[i+1]), .out_sbb(asbb[i+1])
    );
  end

  // variances and covariance
  logic [VW-1:0]     num_nxt, va_nxt, vb_nxt, num_r, va_r, vb_r;
  crps_pkg::status_t st1_nxt, st1_r;
  logic [CNT_W-1:0]  n1_r;
  logic              v1_r;

  assign num_nxt = VW'(an[NUM_ITEMS]) * VW'(asab[NUM_ITEMS])
                 - VW'(asa[NUM_ITEMS]) * VW'(asb[NUM_ITEMS]);
  assign va_nxt  = VW'(an[NUM_ITEMS]) * VW'(asaa[NUM_ITEMS])
                 - VW'(asa[NUM_ITEMS]) * VW'(asa[NUM_ITEMS]);
  assign vb_nxt  = VW'(an[NUM_ITEMS]) * VW'(asbb[NUM_ITEMS])
                 - VW'(asb[NUM_ITEMS]) * VW'(asb[NUM_ITEMS]);

  always_comb begin
    if (an[NUM_ITEMS] == '0) begin
      st1_nxt = crps_pkg::ST_NO_COMMON;
    end else if (va_nxt == '0 || vb_nxt == '0) begin
      st1_nxt = crps_pkg::ST_ZERO_VAR;
    end else begin
      st1_nxt = crps_pkg::ST_VALID;
    end
  end

  // squares and product
  logic [MW-1:0]     mag;
  logic [PW-1:0]     num2_r, prod_r;
  logic              neg2_r, v2_r;
  logic [CNT_W-1:0]  n2_r;
  crps_pkg::status_t st2_r;

  assign mag = num_r[VW-1] ? MW'(-num_r) : num_r[MW-1:0];

  // divider setup
  logic [PW-1:0]     x3, p3;
  logic              q3;

  assign x3 = (num2_r > prod_r) ? prod_r : num2_r;
  assign p3 = (st2_r != crps_pkg::ST_VALID) ? PW'(1) : prod_r;
  assign q3 = (x3 == p3);

  logic              dv  [0:NDIV];
  logic [PW-1:0]     drem [0:NDIV];
  logic [PW-1:0]     dp  [0:NDIV];
  logic [QB-1:0]     dq  [0:NDIV];
  logic              dneg [0:NDIV];
  logic [CNT_W-1:0]  dn  [0:NDIV];
  crps_pkg::status_t dst [0:NDIV];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      dv[0] <= 1'b0;
    end else begin
      v1_r  <= av[NUM_ITEMS];
      v2_r  <= v1_r;
      dv[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
    n1_r    <= an[NUM_ITEMS];
    st1_r   <= st1_nxt;
    num2_r  <= PW'(mag) * PW'(mag);
    prod_r  <= PW'(va_r[MW-1:0]) * PW'(vb_r[MW-1:0]);
    neg2_r  <= num_r[VW-1];
    n2_r    <= n1_r;
    st2_r   <= st1_r;
    drem[0] <= q3 ? '0 : x3;
    dp[0]   <= p3;
    dq[0]   <= QB'(q3);
    dneg[0] <= neg2_r;
    dn[0]   <= n2_r;
    dst[0]  <= st2_r;
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    crps_div_cell #(.PW(PW), .CNT_W(CNT_W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(dv[k]), .in_rem(drem[k]), .in_p(dp[k]), .in_quot(dq[k]),
      .in_neg(dneg[k]), .in_n(dn[k]), .in_status(dst[k]),
      .out_valid(dv[k+1]), .out_rem(drem[k+1]), .out_p(dp[k+1]),
      .out_quot(dq[k+1]), .out_neg(dneg[k+1]), .out_n(dn[k+1]),
      .out_status(dst[k+1])
    );
  end

  // square root chain
  logic              sv  [0:RB];
  logic [QB-1:0]     srem [0:RB];
  logic [RB-1:0]     sroot [0:RB];
  logic              sneg [0:RB];
  logic [CNT_W-1:0]  sn  [0:RB];
  crps_pkg::status_t sst [0:RB];

  assign sv[0]    = dv[NDIV];
  assign srem[0]  = dq[NDIV];
  assign sroot[0] = '0;
  assign sneg[0]  = dneg[NDIV];
  assign sn[0]    = dn[NDIV];
  assign sst[0]   = dst[NDIV];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    crps_sqrt_cell #(.BIT(RB - 1 - j), .CNT_W(CNT_W)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_valid(sv[j]), .in_rem(srem[j]), .in_root(sroot[j]),
      .in_neg(sneg[j]), .in_n(sn[j]), .in_status(sst[j]),
      .out_valid(sv[j+1]), .out_rem(srem[j+1]), .out_root(sroot[j+1]),
      .out_neg(sneg[j+1]), .out_n(sn[j+1]), .out_status(sst[j+1])
    );
  end

  // output register
  logic [crps_pkg::SimWidth-1:0] root_x;

  assign root_x = crps_pkg::SimWidth'(sroot[RB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sv[RB];
    end
  end

  always_ff @(posedge clk) begin
    out_similarity     <= sneg[RB] ? -root_x : root_x;
    out_co_rated_count <= crps_pkg::CountWidth'(sn[RB]);
    out_status         <= sst[RB];
  end

`ifndef NO_ASSERTIONS
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != crps_pkg::ST_VALID |-> out_similarity == '0)
    else $error("flagged result with nonzero similarity");

  a_no_common_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == crps_pkg::ST_NO_COMMON |-> out_co_rated_count == '0)
    else $error("no common items but nonzero count");

  a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_similarity <= 16'sd16384) && (out_similarity >= -16'sd16384))
    else $error("similarity out of range");
`endif

endmodule
